>>> rtl/rgb_to_hsv_pixel_core_assert.svh
// Assertion macros for the RTL.
`ifndef RGB_TO_HSV_PIXEL_CORE_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles, disabled during reset.
`define RHP_ASSERT_AFTER(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

>>> rtl/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

   localparam int unsigned CHAN_W = 8;
   localparam int unsigned HUE_W  = 9;
   localparam int unsigned QUO_W  = 8;
   localparam int unsigned NUM_W  = 16;

   localparam logic [HUE_W-1:0] HUE_RED_BASE   = 9'd0;
   localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 9'd120;
   localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 9'd240;
   localparam logic [HUE_W-1:0] HUE_FULL       = 9'd360;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgbhsv_req_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } rgbhsv_rsp_type;

   typedef struct packed {
      logic              grey;
      logic              neg;
      logic [HUE_W-1:0]  base;
      logic [CHAN_W-1:0] hi;
      logic [CHAN_W-1:0] delta;
      logic [CHAN_W-1:0] mag;
   } rgbhsv_sel_type;

   typedef struct packed {
      logic              grey;
      logic              neg;
      logic [HUE_W-1:0]  base;
      logic [CHAN_W-1:0] bright;
      logic [NUM_W-1:0]  sat_rem;
      logic [CHAN_W-1:0] sat_den;
      logic [QUO_W-1:0]  sat_quo;
      logic [NUM_W-1:0]  hue_rem;
      logic [CHAN_W-1:0] hue_den;
      logic [QUO_W-1:0]  hue_quo;
   } rgbhsv_div_type;

endpackage

`default_nettype wire

>>> rtl/rgb_to_hsv_pixel_core.sv
// RGB to HSV pixel converter, 8 bits per channel.
// Request channel: drive req_pixel and raise start; the request is taken at
// any rising edge where start is high and busy is low. busy is high only
// while reset is asserted, so one pixel can enter every cycle.
// Response channel: rsp_strobe is high for exactly one cycle with rsp_pixel
// holding hue (0..359 degrees), saturation (0..255) and brightness (0..255).
// The receiver cannot stall; each response must be taken when shown.
// A pixel taken on the request port passes through 12 register stages
// before it is shown on the response ports. Throughput: one pixel per
// cycle, set by a pipeline of one input stage, one max/min select stage, one
// constant-multiply stage, eight restoring divide stages (one quotient bit
// each, saturation and hue dividers side by side) and one output stage.
// Responses come out in request order.
// Reset clears every stage valid bit; pixels in flight are dropped and no
// response appears until new requests pass through the pipeline.
`default_nettype none
`include "rgb_to_hsv_pixel_core_assert.svh"

module rgb_to_hsv_pixel_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire rgbhsv_pkg::rgbhsv_req_type req_pixel,
   output logic                            rsp_strobe,
   output rgbhsv_pkg::rgbhsv_rsp_type      rsp_pixel
);
   import rgbhsv_pkg::*;

   localparam int unsigned LATENCY = QUO_W + 4;

   logic              accept;
   logic              in_valid_ff;
   rgbhsv_req_type    in_pix_ff;

   logic              sel_valid_ff;
   rgbhsv_sel_type    sel_ff;
   rgbhsv_sel_type    sel_in;
   logic [CHAN_W-1:0] hi;
   logic [CHAN_W-1:0] lo;

   logic              div_valid_ff [0:QUO_W];
   rgbhsv_div_type    div_ff       [0:QUO_W];
   rgbhsv_div_type    div_in;

   logic              out_valid_ff;
   rgbhsv_rsp_type    out_ff;
   rgbhsv_rsp_type    out_in;
   rgbhsv_div_type    last;
   logic [HUE_W-1:0]  hue_quo_ext;
   logic [HUE_W-1:0]  hue_round;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
      in_pix_ff <= req_pixel;
   end

   always_comb begin
      hi = (in_pix_ff.red > in_pix_ff.green) ? in_pix_ff.red : in_pix_ff.green;
      hi = (hi > in_pix_ff.blue) ? hi : in_pix_ff.blue;
      lo = (in_pix_ff.red < in_pix_ff.green) ? in_pix_ff.red : in_pix_ff.green;
      lo = (lo < in_pix_ff.blue) ? lo : in_pix_ff.blue;
      sel_in.hi    = hi;
      sel_in.delta = hi - lo;
      sel_in.grey  = (hi == lo);
      if (in_pix_ff.red == hi) begin
         sel_in.neg  = in_pix_ff.green < in_pix_ff.blue;
         sel_in.mag  = sel_in.neg ? in_pix_ff.blue - in_pix_ff.green
                                  : in_pix_ff.green - in_pix_ff.blue;
         sel_in.base = sel_in.neg ? HUE_FULL : HUE_RED_BASE;
      end else if (in_pix_ff.green == hi) begin
         sel_in.neg  = in_pix_ff.blue < in_pix_ff.red;
         sel_in.mag  = sel_in.neg ? in_pix_ff.red - in_pix_ff.blue
                                  : in_pix_ff.blue - in_pix_ff.red;
         sel_in.base = HUE_GREEN_BASE;
      end else begin
         sel_in.neg  = in_pix_ff.red < in_pix_ff.green;
         sel_in.mag  = sel_in.neg ? in_pix_ff.green - in_pix_ff.red
                                  : in_pix_ff.red - in_pix_ff.green;
         sel_in.base = HUE_BLUE_BASE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else begin
         sel_valid_ff <= in_valid_ff;
      end
      sel_ff <= sel_in;
   end

   // 255*delta and 60*mag by shift and subtract
   always_comb begin
      div_in.grey    = sel_ff.grey;
      div_in.neg     = sel_ff.neg;
      div_in.base    = sel_ff.base;
      div_in.bright  = sel_ff.hi;
      div_in.sat_rem = (NUM_W'(sel_ff.delta) << 8) - NUM_W'(sel_ff.delta);
      div_in.sat_den = sel_ff.hi;
      div_in.sat_quo = '0;
      div_in.hue_rem = (NUM_W'(sel_ff.mag) << 6) - (NUM_W'(sel_ff.mag) << 2);
      div_in.hue_den = sel_ff.delta;
      div_in.hue_quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= sel_valid_ff;
      end
      div_ff[0] <= div_in;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int unsigned SH = QUO_W - 1 - k;
      logic [NUM_W-1:0] sat_trial;
      logic [NUM_W-1:0] hue_trial;
      rgbhsv_div_type   step_in;

      assign sat_trial = NUM_W'(div_ff[k].sat_den) << SH;
      assign hue_trial = NUM_W'(div_ff[k].hue_den) << SH;

      always_comb begin
         step_in = div_ff[k];
         if (div_ff[k].sat_rem >= sat_trial) begin
            step_in.sat_rem     = div_ff[k].sat_rem - sat_trial;
            step_in.sat_quo[SH] = 1'b1;
         end
         if (div_ff[k].hue_rem >= hue_trial) begin
            step_in.hue_rem     = div_ff[k].hue_rem - hue_trial;
            step_in.hue_quo[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k+1] <= 1'b0;
         end else begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
         div_ff[k+1] <= step_in;
      end
   end

   // negative offset floors: base - ceil(60*mag/delta)
   always_comb begin
      last        = div_ff[QUO_W];
      hue_quo_ext = HUE_W'(last.hue_quo);
      hue_round   = HUE_W'(last.hue_rem != '0);
      out_in.brightness = last.bright;
      if (last.grey) begin
         out_in.hue        = '0;
         out_in.saturation = '0;
      end else begin
         out_in.hue        = last.neg ? last.base - hue_quo_ext - hue_round
                                      : last.base + hue_quo_ext;
         out_in.saturation = last.sat_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_valid_ff[QUO_W];
      end
      out_ff <= out_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_pixel  = out_ff;

   `RHP_ASSERT_NOW(a_hue_range, clock, reset, rsp_strobe, rsp_pixel.hue < HUE_FULL, "hue out of range")
   `RHP_ASSERT_NOW(a_grey_hue, clock, reset, rsp_strobe && rsp_pixel.saturation == '0, rsp_pixel.hue == '0, "grey pixel with nonzero hue")
   `RHP_ASSERT_AFTER(a_latency, clock, reset, accept, LATENCY, rsp_strobe, "request lost in pipeline")
   `RHP_ASSERT_NOW(a_no_spurious, clock, reset, rsp_strobe, $past(accept, LATENCY), "response without request")

endmodule

`default_nettype wire
